/* rtl/core/slf_pkg.sv */
// ----------------------------------------------------------------------------
// slf_pkg: shared types and constants for the streaming line fit
// Sample and result payload structs, default sizes, status codes.
// ----------------------------------------------------------------------------
package slf_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int MAX_PAIRS_LOG2_DEF = 20;

    localparam int CNT_W  = 21;
    localparam int SUM_W  = 37;
    localparam int SQ_W   = 53;
    localparam int PROD_W = 128;
    localparam int GAIN_W = 32;
    localparam int BIAS_W = 40;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic [15:0] sample_x;
        logic [15:0] sample_y;
        logic        last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] fit_gain;
        logic signed [BIAS_W-1:0] fit_bias;
        logic [CNT_W-1:0]         sample_count;
        logic [1:0]               fit_status;
    } fit_t;

    // request from the sequencer to the shared multiplier
    typedef struct packed {
        logic              start;
        logic [SQ_W-1:0]   op_a;
        logic [SQ_W-1:0]   op_b;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [PROD_W-1:0] num;
        logic [PROD_W-1:0] den;
    } div_req_t;

endpackage

/* rtl/core/streaming_line_fit.sv */
// ----------------------------------------------------------------------------
// streaming_line_fit: least-squares line fit over a stream of sample pairs
// Accumulates n, Sx, Sy, Sxx, Sxy; on the last pair solves gain and bias.
// ----------------------------------------------------------------------------
//  channel | ports             | payload   | direction
//  sample  | s_valid/s_ready   | sample_t  | in
//  result  | m_valid/m_ready   | fit_t     | out
//
//  A pair without the last mark is accepted, then accumulated (x*x and x*y
//  use two small multipliers, not the shared one). A last pair is accepted
//  and accumulated, then runs six products through the shared multiplier,
//  a check state and two divisions in the shared divider before m_valid
//  rises; the divisions are skipped when there are too few pairs or x is
//  degenerate. Reset clears sums and control at once; a stalled result
//  holds m_valid and the block takes no pair until it is taken.
// ----------------------------------------------------------------------------
module streaming_line_fit #(
    parameter int SAMPLE_BITS    = slf_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_PAIRS_LOG2 = slf_pkg::MAX_PAIRS_LOG2_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  slf_pkg::sample_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output slf_pkg::fit_t     m_data
);
    localparam int W = slf_pkg::PROD_W;

    localparam logic [3:0] S_IDLE = 4'd0, S_ACC = 4'd1, S_MUL = 4'd2, S_MWAIT = 4'd3,
                           S_DCHK = 4'd4, S_DIV = 4'd5, S_DWAIT = 4'd6, S_OUT = 4'd7;

    logic [3:0]                 state_reg;
    logic [2:0]                 idx_reg;
    logic                       which_reg;
    slf_pkg::sample_t           in_reg;
    logic [slf_pkg::CNT_W-1:0]  cnt_reg;
    logic [slf_pkg::SUM_W-1:0]  sx_reg, sy_reg;
    logic [slf_pkg::SQ_W-1:0]   sxx_reg, sxy_reg;
    logic                       ovf_reg, sat_reg;
    logic                       skip_reg;
    logic [W-1:0]               p_reg [6];
    logic [W-1:0]               d_reg;
    slf_pkg::fit_t              out_reg;
    logic                       ovf_in;

    slf_pkg::mul_req_t          mreq;
    slf_pkg::div_req_t          dreq;
    logic                       mdone, ddone, dneg;
    logic [W-1:0]               mprod, dquot;
    logic [W-1:0]               pp, pm;

    slf_mul u_mul (.aclk, .aresetn, .req(mreq), .done(mdone), .prod(mprod));
    slf_div u_div (.aclk, .aresetn, .req(dreq), .done(ddone), .quot(dquot), .neg(dneg));

    // products: n*Sxx, Sx*Sx, n*Sxy, Sx*Sy, Sxx*Sy, Sx*Sxy
    always_comb begin
        mreq.start = (state_reg == S_MUL);
        mreq.op_a  = '0;
        mreq.op_b  = '0;
        case (idx_reg)
            3'd0: begin mreq.op_a = 53'(cnt_reg); mreq.op_b = sxx_reg; end
            3'd1: begin mreq.op_a = 53'(sx_reg);  mreq.op_b = 53'(sx_reg); end
            3'd2: begin mreq.op_a = 53'(cnt_reg); mreq.op_b = sxy_reg; end
            3'd3: begin mreq.op_a = 53'(sx_reg);  mreq.op_b = 53'(sy_reg); end
            3'd4: begin mreq.op_a = sxx_reg;      mreq.op_b = 53'(sy_reg); end
            default: begin mreq.op_a = 53'(sx_reg); mreq.op_b = sxy_reg; end
        endcase
    end

    assign pp = which_reg ? p_reg[4] : p_reg[2];
    assign pm = which_reg ? p_reg[5] : p_reg[3];
    assign dreq.start = (state_reg == S_DIV);
    assign dreq.neg   = (pp < pm);
    assign dreq.num   = ((pp < pm) ? (pm - pp) : (pp - pm)) << 16;
    assign dreq.den   = d_reg;

    assign ovf_in = (SAMPLE_BITS < 16 && ((s_data.sample_x >> SAMPLE_BITS) != 0
                     || (s_data.sample_y >> SAMPLE_BITS) != 0));

    logic [W-1:0] top, bound;
    logic         qsat;
    assign top   = which_reg ? (W'(1) << 39) : (W'(1) << 31);
    assign bound = dneg ? top : top - W'(1);
    assign qsat  = dquot > bound;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            which_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (skip_reg || 32'(cnt_reg) >= (32'd1 << MAX_PAIRS_LOG2)) begin
                        ovf_reg <= 1'b1;
                    end
                    if (!skip_reg && 32'(cnt_reg) < (32'd1 << MAX_PAIRS_LOG2)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        sx_reg  <= sx_reg + 37'(in_reg.sample_x);
                        sy_reg  <= sy_reg + 37'(in_reg.sample_y);
                        sxx_reg <= sxx_reg + 53'(in_reg.sample_x) * 53'(in_reg.sample_x);
                        sxy_reg <= sxy_reg + 53'(in_reg.sample_x) * 53'(in_reg.sample_y);
                    end
                    idx_reg   <= '0;
                    which_reg <= 1'b0;
                    sat_reg   <= 1'b0;
                    state_reg <= in_reg.last_sample ? S_MUL : S_IDLE;
                end
                S_MUL: state_reg <= S_MWAIT;
                S_MWAIT: begin
                    if (mdone) begin
                        p_reg[idx_reg] <= mprod;
                        idx_reg        <= idx_reg + 3'd1;
                        state_reg      <= (idx_reg == 3'd5) ? S_DCHK : S_MUL;
                    end
                end
                S_DCHK: begin
                    d_reg <= p_reg[0] - p_reg[1];
                    out_reg.sample_count <= cnt_reg;
                    out_reg.fit_gain     <= '0;
                    out_reg.fit_bias     <= '0;
                    if (cnt_reg < 21'd2) begin
                        out_reg.fit_status <= slf_pkg::ST_FEW;
                        state_reg          <= S_OUT;
                    end else if (p_reg[0] == p_reg[1]) begin
                        out_reg.fit_status <= slf_pkg::ST_DEGEN;
                        state_reg          <= S_OUT;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (ddone) begin
                        if (!which_reg) begin
                            out_reg.fit_gain <= qsat ? (dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                                     : (dneg ? -dquot[31:0] : dquot[31:0]);
                            which_reg <= 1'b1;
                            sat_reg   <= qsat;
                            state_reg <= S_DIV;
                        end else begin
                            out_reg.fit_bias <= qsat ? (dneg ? 40'sh80_0000_0000
                                                             : 40'sh7F_FFFF_FFFF)
                                                     : (dneg ? -dquot[39:0] : dquot[39:0]);
                            out_reg.fit_status <= (sat_reg || qsat || ovf_reg)
                                                  ? slf_pkg::ST_SAT : slf_pkg::ST_OK;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                        cnt_reg   <= '0;
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        sxx_reg   <= '0;
                        sxy_reg   <= '0;
                        ovf_reg   <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // drop out-of-range samples: flag taken at accept time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b0;
        end else if (state_reg == S_IDLE && s_valid) begin
            skip_reg <= ovf_in;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;
endmodule

/* rtl/core/slf_mul.sv */
// ----------------------------------------------------------------------------
// slf_mul: shared 53x53 multiplier
// Sequential: one 32x32 partial product per cycle, four partial products;
// the full product is ready when done rises.
// ----------------------------------------------------------------------------
module slf_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  slf_pkg::mul_req_t             req,
    output logic                          done,
    output logic [slf_pkg::PROD_W-1:0]    prod
);
    logic [1:0]                    step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic [63:0]                   a_reg, b_reg;
    logic [slf_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic [31:0]                   pa, pb;
    logic [63:0]                   pp_reg;
    logic                          pv_reg;
    logic [1:0]                    pstep_reg;
    logic                          done_reg;

    assign pa = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign pb = step_reg[1] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = 2'd0;
            acc_next  = '0;
        end else if (busy_reg) begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
            end
        end
        if (pv_reg) begin
            acc_next = acc_reg + ({64'd0, pp_reg} << (7'(pstep_reg[0]) * 7'd32
                                                    + 7'(pstep_reg[1]) * 7'd32));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            pv_reg   <= busy_reg && !req.start;
            done_reg <= pv_reg && (pstep_reg == 2'd3);
        end
        if (req.start) begin
            a_reg <= {11'd0, req.op_a};
            b_reg <= {11'd0, req.op_b};
        end
        pp_reg    <= 64'(pa) * 64'(pb);
        pstep_reg <= step_reg;
        acc_reg   <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

/* rtl/core/slf_div.sv */
// ----------------------------------------------------------------------------
// slf_div: shared restoring divider
// One quotient bit per cycle over a 128-bit dividend; sign passed on neg.
// ----------------------------------------------------------------------------
module slf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  slf_pkg::div_req_t             req,
    output logic                          done,
    output logic [slf_pkg::PROD_W-1:0]    quot,
    output logic                          neg
);
    localparam int W = slf_pkg::PROD_W;

    logic [W-1:0]   num_reg, den_reg, rem_reg, q_reg;
    logic [W:0]     trial;
    logic [7:0]     cnt_reg;
    logic           busy_reg, done_reg, neg_reg;

    assign trial = {rem_reg, num_reg[W-1]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 8'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            neg_reg <= req.neg;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            if (!trial[W]) begin
                rem_reg <= trial[W-1:0];
                q_reg   <= {q_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[W-2:0], num_reg[W-1]};
                q_reg   <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign neg  = neg_reg;
endmodule

/* test/streaming_line_fit_checker.sv */
// ----------------------------------------------------------------------------
// streaming_line_fit_checker: fit predictor and result scoreboard
// Watches both channels, runs its own exact line fit over every accepted
// request and compares each result, field by field, with the oldest fit due.
// ----------------------------------------------------------------------------
module streaming_line_fit_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  slf_pkg::sample_t s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  slf_pkg::fit_t    m_data,
    output int               fail_count,
    output int               fits_pending
);
    logic [slf_pkg::CNT_W-1:0] pairs_held;
    logic [slf_pkg::SUM_W-1:0] acc_x, acc_y;
    logic [slf_pkg::SQ_W-1:0]  acc_xx, acc_xy;
    logic                      lost_pair;
    slf_pkg::fit_t             fits_due[$];

    initial begin
        fail_count   = 0;
        fits_pending = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // (p - m) * 2^16 / d, truncated toward zero, clamped to mag_bits + 1 bits
    function automatic logic [63:0] solve_quot(input logic [127:0] p, input logic [127:0] m,
                                               input logic [127:0] d, input int mag_bits,
                                               inout logic sat);
        logic         neg;
        logic [127:0] mag, q;
        logic [63:0]  top, bound;
        neg   = p < m;
        mag   = neg ? m - p : p - m;
        q     = (mag << 16) / d;
        top   = 64'd1 << mag_bits;
        bound = neg ? top : top - 64'd1;
        if (q[127:64] != 0 || q[63:0] > bound) begin
            sat = 1'b1;
            return bound;
        end
        return neg ? 64'd0 - q[63:0] : q[63:0];
    endfunction

    task automatic fit_pair(input slf_pkg::sample_t smp);
        logic [127:0]  n, sx, sy, sxx, sxy, dnm;
        logic          sat;
        slf_pkg::fit_t f;
        if (pairs_held >= (slf_pkg::CNT_W'(1) << slf_pkg::MAX_PAIRS_LOG2_DEF)) begin
            lost_pair = 1'b1;
        end else begin
            pairs_held++;
            acc_x  += slf_pkg::SUM_W'(smp.sample_x);
            acc_y  += slf_pkg::SUM_W'(smp.sample_y);
            acc_xx += slf_pkg::SQ_W'(smp.sample_x) * slf_pkg::SQ_W'(smp.sample_x);
            acc_xy += slf_pkg::SQ_W'(smp.sample_x) * slf_pkg::SQ_W'(smp.sample_y);
        end
        if (!smp.last_sample) return;
        n = 128'(pairs_held); sx = 128'(acc_x); sy = 128'(acc_y);
        sxx = 128'(acc_xx); sxy = 128'(acc_xy);
        f = '0;
        f.sample_count = pairs_held;
        sat = 1'b0;
        dnm = n * sxx - sx * sx;
        if (pairs_held < 2) begin
            f.fit_status = slf_pkg::ST_FEW;
        end else if (dnm == 0) begin
            f.fit_status = slf_pkg::ST_DEGEN;
        end else begin
            f.fit_gain   = slf_pkg::GAIN_W'(solve_quot(n * sxy, sx * sy, dnm, 31, sat));
            f.fit_bias   = slf_pkg::BIAS_W'(solve_quot(sxx * sy, sx * sxy, dnm, 39, sat));
            f.fit_status = (sat || lost_pair) ? slf_pkg::ST_SAT : slf_pkg::ST_OK;
        end
        fits_due.insert(fits_due.size(), f);
        pairs_held = '0; acc_x = '0; acc_y = '0; acc_xx = '0; acc_xy = '0;
        lost_pair = 1'b0;
    endtask

    always @(posedge aclk) begin
        slf_pkg::fit_t want;
        if (!aresetn) begin
            pairs_held = '0; acc_x = '0; acc_y = '0; acc_xx = '0; acc_xy = '0;
            lost_pair = 1'b0;
            fits_due.delete();
        end else begin
            if (s_valid && s_ready) fit_pair(s_data);
            if (m_valid && m_ready) begin
                if (fits_due.size() == 0) begin
                    report("unexpected result", 64'(m_data.fit_gain), 64'd0);
                end else begin
                    want = fits_due[0];
                    fits_due.delete(0);
                    if (m_data.fit_gain !== want.fit_gain)
                        report("fit_gain", 64'(m_data.fit_gain), 64'(want.fit_gain));
                    if (m_data.fit_bias !== want.fit_bias)
                        report("fit_bias", 64'(m_data.fit_bias), 64'(want.fit_bias));
                    if (m_data.sample_count !== want.sample_count)
                        report("sample_count", 64'(m_data.sample_count),
                               64'(want.sample_count));
                    if (m_data.fit_status !== want.fit_status)
                        report("fit_status", 64'(m_data.fit_status), 64'(want.fit_status));
                end
            end
        end
        fits_pending = fits_due.size();
    end

endmodule

/* test/streaming_line_fit_tb.sv */
// ----------------------------------------------------------------------------
// streaming_line_fit_tb: stimulus and verdict for the streaming line fit
// Directed sets for the edge cases, then random sets of sample pairs with
// bursty requests, a stalling receiver and one long result hold-off.
// ----------------------------------------------------------------------------
module streaming_line_fit_tb;

    localparam int IDLE_LIMIT = 4000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    slf_pkg::sample_t s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    slf_pkg::fit_t    m_data;
    int               fail_count, fits_pending;
    int               burst_left = 0;
    int               idle_cycles = 0;

    always #2 aclk = ~aclk;

    streaming_line_fit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    streaming_line_fit_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .fits_pending(fits_pending)
    );

    // offer one request, hold it until taken; gaps come between bursts
    task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_data  <= '{sample_x: x, sample_y: y, last_sample: last};
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic send_set(input int len, input logic [15:0] x_lo, input logic [15:0] x_hi);
        for (int i = 0; i < len; i++)
            send_pair(16'($urandom_range(x_lo, x_hi)), 16'($urandom), i == len - 1);
    endtask

    // receiver: random stall pattern, one long hold-off
    initial begin
        int level, cyc;
        level = 50;
        cyc = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 3000) begin
                m_ready <= 1'b0;
                repeat (900) @(posedge aclk);
            end
            if (cyc % 200 == 0) level = $urandom_range(0, 3) * 33;
            m_ready <= ($urandom_range(0, 99) >= level);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // single pair: too few samples
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        // identical x: degenerate
        send_pair(16'd7, 16'd0, 1'b0);
        send_pair(16'd7, 16'hFFFF, 1'b1);
        // exact line y = 2x + 3
        send_pair(16'd0, 16'd3, 1'b0);
        send_pair(16'd10, 16'd23, 1'b0);
        send_pair(16'd20, 16'd43, 1'b1);
        // steep rise: gain saturates high
        send_pair(16'd0, 16'd0, 1'b0);
        send_pair(16'd1, 16'hFFFF, 1'b1);
        // steep fall at the top of x: gain low, bias high both saturate
        send_pair(16'hFFFE, 16'hFFFF, 1'b0);
        send_pair(16'hFFFF, 16'd0, 1'b1);
        // rise at the top of x: bias saturates low
        send_pair(16'hFFFE, 16'd0, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        // negative slope, extremes of both fields
        send_pair(16'd0, 16'hFFFF, 1'b0);
        send_pair(16'hFFFF, 16'd0, 1'b0);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        // random part: mostly short sets, some with narrow x, a few long ones
        for (int k = 0; k < 210; k++) begin
            if (k == 120) begin
                s_valid <= 1'b0;
                burst_left = 0;
                wait (fits_pending == 0);
                @(posedge aclk);
            end
            case ($urandom_range(0, 9))
                0:       send_set($urandom_range(1, 2), 16'd0, 16'hFFFF);
                1:       send_set($urandom_range(2, 10), 16'd100, 16'd101);
                2:       send_set($urandom_range(2, 6), 16'h4000, 16'h4000);
                3:       send_set($urandom_range(20, 60), 16'd0, 16'hFFFF);
                default: send_set($urandom_range(2, 8), 16'd0, 16'hFFFF);
            endcase
        end
        send_set(300, 16'd0, 16'hFFFF);
        s_valid <= 1'b0;
        wait (fits_pending == 0);
        repeat (400) @(posedge aclk);
        if (fail_count == 0 && fits_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
